### rtl/tets_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tets_pkg
// Types, constants and the half-to-single widening function shared by the
// tensor element converter.
// ----------------------------------------------------------------------------
package tets_pkg;

    typedef enum logic [1:0] {
        FMT_SINGLE = 2'd0,
        FMT_HALF   = 2'd1,
        FMT_BF16   = 2'd2,
        FMT_UNSUP  = 2'd3
    } t_fmt;

    localparam int unsigned ELEM_W    = 32;
    localparam int unsigned HALF_W    = 16;
    localparam int unsigned H_FRAC_W  = 10;
    localparam int unsigned H_EXP_W   = 5;
    localparam int unsigned S_EXP_W   = 8;
    localparam int unsigned FRAC_PAD  = 13;
    localparam int unsigned EXP_REBIAS = 112;
    localparam logic [H_EXP_W-1:0] H_EXP_MAX = 5'h1F;
    localparam logic [S_EXP_W-1:0] S_EXP_MAX = 8'hFF;

    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_FORMAT = 1'b0;

    // shift count for a subnormal fraction: leading zeros plus the hidden bit
    function automatic logic [3:0] sub_shift(input logic [H_FRAC_W-1:0] frac);
        logic [3:0] lz;
        lz = 4'(H_FRAC_W);
        for (int i = 0; i < H_FRAC_W; i++) begin
            if (frac[i]) begin
                lz = 4'(H_FRAC_W - 1 - i);
            end
        end
        return 4'(lz + 4'd1);
    endfunction

    function automatic logic [ELEM_W-1:0] half_to_single(input logic [HALF_W-1:0] h);
        logic                sign;
        logic [H_EXP_W-1:0]  ex;
        logic [H_FRAC_W-1:0] fr;
        logic [3:0]          sh;
        logic [H_FRAC_W:0]   fr_norm;
        logic [S_EXP_W-1:0]  s_exp;
        logic [ELEM_W-1:0]   res;
        sign    = h[HALF_W-1];
        ex      = h[HALF_W-2 -: H_EXP_W];
        fr      = h[H_FRAC_W-1:0];
        sh      = sub_shift(fr);
        fr_norm = {1'b0, fr} << sh;
        if (ex == '0) begin
            if (fr == '0) begin
                res = {sign, 31'd0};
            end else begin
                s_exp = S_EXP_W'(EXP_REBIAS + 1) - S_EXP_W'(sh);
                res   = {sign, s_exp, fr_norm[H_FRAC_W-1:0], FRAC_PAD'(0)};
            end
        end else if (ex == H_EXP_MAX) begin
            res = {sign, S_EXP_MAX, fr, FRAC_PAD'(0)};
        end else begin
            s_exp = S_EXP_W'(ex) + S_EXP_W'(EXP_REBIAS);
            res   = {sign, s_exp, fr, FRAC_PAD'(0)};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### rtl/tets_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tets_in_if
// Valid/ready channel carrying one raw tensor element per item.
// ----------------------------------------------------------------------------
interface tets_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] raw_element;
    logic        final_element;

    modport source (output valid, output raw_element, output final_element, input ready);
    modport sink   (input valid, input raw_element, input final_element, output ready);
endinterface
`default_nettype wire

### rtl/tets_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tets_out_if
// Valid/ready channel carrying one single-precision result per item.
// ----------------------------------------------------------------------------
interface tets_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] single_bits;
    logic        final_flag;
    logic        format_error;

    modport source (output valid, output single_bits, output final_flag,
                    output format_error, input ready);
    modport sink   (input valid, input single_bits, input final_flag,
                    input format_error, output ready);
endinterface
`default_nettype wire

### rtl/tensor_element_to_single.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tensor_element_to_single
// Converts raw tensor elements (single, half or bfloat16) to IEEE single.
// ----------------------------------------------------------------------------
// One item is taken per cycle while the output is not stalled: an input
// register holds the raw element and a result register holds the
// converted word, with the half-precision leading-zero count and exponent
// rebias in the logic between them. Each stage advances whenever it is empty
// or its downstream side takes an item, so a full stream runs at one item per
// cycle. The element format register is at byte address 0 of the APB port and
// should only be written while no items are in flight.
module tensor_element_to_single (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    tets_in_if.sink                             i_elem,
    tets_out_if.source                          o_single,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [tets_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [tets_pkg::PDATA_W-1:0]   pwdata,
    output logic      [tets_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready
);

    tets_pkg::t_fmt r_fmt;
    logic           cfg_wr;
    logic           cfg_sel;

    logic        r_s1_valid;
    logic [31:0] r_s1_raw;
    logic        r_s1_final;
    logic        s1_ready;

    logic        r_s2_valid;
    logic [31:0] r_s2_bits;
    logic        r_s2_final;
    logic        r_s2_err;
    logic        s2_ready;

    logic [31:0] n_bits;
    logic        n_err;

    // configuration
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[tets_pkg::PADDR_W-1:2] == tets_pkg::REG_FORMAT);
    assign cfg_wr  = psel && penable && pwrite && pready && cfg_sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= tets_pkg::FMT_SINGLE;
        end else if (cfg_wr) begin
            r_fmt <= tets_pkg::t_fmt'(pwdata[1:0]);
        end
    end

    always_comb begin
        prdata = '0;
        if (cfg_sel) begin
            prdata[1:0] = r_fmt;
        end
    end

    // stage handshakes
    assign s2_ready       = !r_s2_valid || o_single.ready;
    assign s1_ready       = !r_s1_valid || s2_ready;
    assign i_elem.ready   = s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= i_elem.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && i_elem.valid) begin
            r_s1_raw   <= i_elem.raw_element;
            r_s1_final <= i_elem.final_element;
        end
    end

    // conversion
    always_comb begin
        n_bits = '0;
        n_err  = 1'b0;
        case (r_fmt)
            tets_pkg::FMT_SINGLE: n_bits = r_s1_raw;
            tets_pkg::FMT_HALF:   n_bits = tets_pkg::half_to_single(r_s1_raw[15:0]);
            tets_pkg::FMT_BF16:   n_bits = {r_s1_raw[15:0], 16'd0};
            default:              n_err  = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_s2_bits  <= n_bits;
            r_s2_final <= r_s1_final;
            r_s2_err   <= n_err;
        end
    end

    assign o_single.valid        = r_s2_valid;
    assign o_single.single_bits  = r_s2_bits;
    assign o_single.final_flag   = r_s2_final;
    assign o_single.format_error = r_s2_err;

    // checks
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_err) |-> (r_s2_bits == '0))
        else $error("format error item carries non-zero bits");

    a_s1_to_s2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && s2_ready) |=> r_s2_valid)
        else $error("stage one item lost on its way to the result register");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_wr |=> (r_fmt == tets_pkg::t_fmt'($past(pwdata[1:0]))))
        else $error("format register not updated by write");

endmodule
`default_nettype wire
